// ----- hw/rtl/csa_pkg.sv -----
`default_nettype none

package csa_pkg;

	localparam int ADDR_BITS  = 30;
	localparam int OWNER_BITS = 16;
	// Cell indices are carried on this many bits, so the table can address at most 64 segments.
	localparam int IDX_BITS   = 6;

	localparam logic [ADDR_BITS-1:0] MEM_SIZE_RESET = 30'd1048576;
	localparam logic REG_MEM_SIZE = 1'b0;

	typedef enum logic [1:0] {
		ACT_REQUEST = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_COMPACT = 2'd2,
		ACT_REPORT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FIT_FIRST   = 2'd0,
		FIT_BEST    = 2'd1,
		FIT_WORST   = 2'd2,
		FIT_INVALID = 2'd3
	} fit_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_BAD_SIZE = 3'd1,
		STAT_NO_ROOM  = 3'd2,
		STAT_BAD_FIT  = 3'd3,
		STAT_NO_OWNER = 3'd4,
		STAT_FULL     = 3'd5
	} status_t;

	typedef struct packed {
		action_t                action;
		logic [OWNER_BITS-1:0]  owner_id;
		logic [ADDR_BITS-1:0]   request_size;
		fit_t                   fit_strategy;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [ADDR_BITS-1:0]   segment_begin;
		logic [ADDR_BITS-1:0]   segment_end;
		logic [OWNER_BITS-1:0]  segment_owner;
		logic                   segment_used;
		logic                   last;
	} rsp_t;

	// One table entry. Slots that hold no segment have valid low and read as zero.
	typedef struct packed {
		logic                   valid;
		logic                   taken;
		logic [OWNER_BITS-1:0]  holder;
		logic [ADDR_BITS-1:0]   start;
		logic [ADDR_BITS-1:0]   len;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{valid: 1'b1, taken: 1'b0, holder: '0, start: '0,
		len: MEM_SIZE_RESET};

	typedef enum logic [2:0] {
		CELL_HOLD    = 3'd0,
		CELL_ROTATE  = 3'd1,
		CELL_INSERT  = 3'd2,
		CELL_SQUEEZE = 3'd3,
		CELL_WRITE   = 3'd4,
		CELL_INIT    = 3'd5
	} cell_op_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t               op;
		logic [IDX_BITS-1:0]    idx;
		logic                   split;
		logic [ADDR_BITS-1:0]   size;
		logic [OWNER_BITS-1:0]  owner;
		entry_t                 wr;
	} cell_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE    = 4'd0,
		S_SEARCH  = 4'd1,
		S_DECIDE  = 4'd2,
		S_INSERT  = 4'd3,
		S_STREAM  = 4'd4,
		S_SQUEEZE = 4'd5,
		S_TOPHOLE = 4'd6,
		S_REPORT  = 4'd7,
		S_RESP    = 4'd8
	} state_t;

	function automatic rsp_t rsp_blank(input status_t s);
		rsp_t r;
		r = '0;
		r.status = s;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/contiguous_segment_allocator.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_t: action, owner, size, fit
// rsp       out        rsp_valid/rsp_ready  rsp_t: status, segment, last
// apb       in         psel/penable/pready  memory_size at byte address 0
//
// Every walk moves the table one cell per cycle past the head of a chain of MAX_SEGMENTS cells,
// but a report walk holds on a segment while the output register is full. Allocate: a search
// walk, a decide and an insert state, then the result; decide skips the insert when nothing fits
// or a split meets a full table, and a zero size or an invalid fit strategy goes straight to it.
// Release: a merge pass, a squeeze pass, the result; compact packs instead and adds a top hole.
// Reset leaves one hole of 1048576 bytes; a memory_size write while idle reinitializes it. The
// result state stalls while the output register is full, then the idle state takes a request.
module contiguous_segment_allocator
	import csa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_ready,
	input  wire req_t        req,
	output      logic        rsp_valid,
	input  wire logic        rsp_ready,
	output      rsp_t        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SEGMENTS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SEGMENTS);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;      // position within the current walk of the chain
	logic [CNT_W-1:0] count_q;    // number of segments in the table
	logic [CNT_W-1:0] wcnt_q;     // segments written back during a stream pass
	req_t req_q;
	logic [ADDR_BITS-1:0] mem_size_q;
	logic found_q;
	logic hit_q;
	logic [IDX_BITS-1:0] pick_q;
	entry_t pick_e_q;
	entry_t pend_q;
	logic [ADDR_BITS-1:0] addr_q;
	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	cell_cmd_t cmd;
	entry_t feed;
	entry_t head;

	logic cfg_wr;
	logic [ADDR_BITS-1:0] cfg_size;
	logic req_acc;
	logic rsp_free;
	logic cand;
	logic better;
	logic split;
	logic top_ok;
	logic rep_adv;
	logic rep_emit;
	logic rsp_load;
	rsp_t rsp_d;
	rsp_t rep_rsp;
	entry_t st_in;
	entry_t st_out;
	entry_t pend_d;
	logic [ADDR_BITS-1:0] addr_d;
	logic hit_now;
	logic flush;

	// Configuration port. A zero size is taken as one byte.
	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & (paddr[2] == REG_MEM_SIZE);
	assign cfg_size = (pwdata[ADDR_BITS-1:0] == '0) ? ADDR_BITS'(1) : pwdata[ADDR_BITS-1:0];
	assign prdata   = (paddr[2] == REG_MEM_SIZE) ? 32'(mem_size_q) : 32'd0;

	assign req_acc  = req_valid & req_ready;
	assign rsp_free = ~rsp_valid_q | rsp_ready;
	assign rsp      = rsp_q;
	assign rsp_valid = rsp_valid_q;

	csa_chain #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.feed   (feed),
		.head   (head)
	);

	// Search: the segment at the head of the chain is a candidate if it is a live hole
	// large enough. First fit keeps the first one; best and worst fit replace only on a
	// strictly smaller or larger hole, so ties keep the lowest address.
	assign cand = (cnt_q < count_q) && !head.taken && (head.len >= req_q.request_size);
	assign better = !found_q
		|| (req_q.fit_strategy == FIT_BEST && head.len < pick_e_q.len)
		|| (req_q.fit_strategy == FIT_WORST && head.len > pick_e_q.len);
	assign split  = pick_e_q.len > req_q.request_size;
	assign top_ok = (addr_q < mem_size_q) && (wcnt_q < CNT_FULL);

	// Report walks the ring; it waits on a segment when the output register is busy.
	assign rep_emit = (cnt_q < count_q) && rsp_free;
	assign rep_adv  = (cnt_q >= count_q) || rsp_free;
	always_comb begin
		rep_rsp = '0;
		rep_rsp.status        = STAT_OK;
		rep_rsp.segment_begin = head.start;
		rep_rsp.segment_end   = head.start + head.len - ADDR_BITS'(1);
		rep_rsp.segment_owner = head.taken ? head.holder : '0;
		rep_rsp.segment_used  = head.taken;
		rep_rsp.last          = (cnt_q == count_q - CNT_W'(1));
	end

	// Stream unit for release and compact. Each entry leaves through a one-entry holding
	// register, so the ring shifts MAX_SEGMENTS+1 times; on the last shift the head holds the
	// empty slot written on the first one and the held entry is flushed out.
	assign flush = (cnt_q == CNT_FULL);
	always_comb begin
		st_in   = flush ? entry_t'('0) : head;
		hit_now = 1'b0;
		st_out  = pend_q;
		pend_d  = pend_q;
		addr_d  = addr_q;
		if (req_q.action == ACT_RELEASE) begin
			if (st_in.valid && st_in.taken && st_in.holder == req_q.owner_id) begin
				st_in.taken  = 1'b0;
				st_in.holder = '0;
				hit_now      = 1'b1;
			end
			if (flush) begin
				st_out = pend_q;
				pend_d = '0;
			end else if (!st_in.valid) begin
				st_out = '0;
			end else if (pend_q.valid && !pend_q.taken && !st_in.taken) begin
				// Two holes in a row merge into the held one and leave a gap behind.
				st_out     = '0;
				pend_d.len = pend_q.len + st_in.len;
			end else begin
				st_out = pend_q;
				pend_d = st_in;
			end
		end else begin
			// Compact keeps only owned segments and packs them from address zero up.
			st_out = pend_q;
			if (st_in.valid && st_in.taken) begin
				pend_d       = st_in;
				pend_d.start = addr_q;
				addr_d       = addr_q + st_in.len;
			end else begin
				pend_d = '0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					unique case (req.action)
						ACT_REQUEST: begin
							if (req.request_size == '0 || req.fit_strategy == FIT_INVALID) begin
								state_d = S_RESP;
							end else begin
								state_d = S_SEARCH;
							end
						end
						ACT_RELEASE, ACT_COMPACT: state_d = S_STREAM;
						ACT_REPORT: state_d = S_REPORT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SEARCH: begin
				if (cnt_q == CNT_LAST) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!found_q || (split && count_q == CNT_FULL)) begin
					state_d = S_RESP;
				end else begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: state_d = S_RESP;
			S_STREAM: begin
				if (flush) begin
					state_d = S_SQUEEZE;
				end
			end
			S_SQUEEZE: begin
				if (cnt_q == CNT_LAST) begin
					state_d = (req_q.action == ACT_COMPACT) ? S_TOPHOLE : S_RESP;
				end
			end
			S_TOPHOLE: state_d = S_RESP;
			S_REPORT: begin
				if (rep_adv && cnt_q == CNT_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and chain commands for each state.
	always_comb begin
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		rsp_d     = res_q;
		feed      = head;
		cmd       = '0;
		cmd.op    = CELL_HOLD;
		cmd.size  = req_q.request_size;
		cmd.owner = req_q.owner_id;
		if (cfg_wr) begin
			cmd.op = CELL_INIT;
			cmd.wr = '{valid: 1'b1, taken: 1'b0, holder: '0, start: '0, len: cfg_size};
		end
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_SEARCH: begin
				cmd.op = CELL_ROTATE;
			end
			S_INSERT: begin
				cmd.op    = CELL_INSERT;
				cmd.idx   = pick_q;
				cmd.split = split;
				cmd.wr    = '{valid: 1'b1, taken: 1'b0, holder: '0,
					start: pick_e_q.start + req_q.request_size,
					len: pick_e_q.len - req_q.request_size};
			end
			S_STREAM: begin
				cmd.op = CELL_ROTATE;
				feed   = st_out;
			end
			S_SQUEEZE: begin
				cmd.op = CELL_SQUEEZE;
				feed   = '0;
			end
			S_TOPHOLE: begin
				if (top_ok) begin
					cmd.op  = CELL_WRITE;
					cmd.idx = IDX_BITS'(wcnt_q);
					cmd.wr  = '{valid: 1'b1, taken: 1'b0, holder: '0, start: addr_q,
						len: mem_size_q - addr_q};
				end
			end
			S_REPORT: begin
				if (rep_adv) begin
					cmd.op = CELL_ROTATE;
				end
				rsp_load = rep_emit;
				rsp_d    = rep_rsp;
			end
			S_RESP: begin
				rsp_load = rsp_free;
			end
			default: begin
				cmd.op = cfg_wr ? CELL_INIT : CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= CNT_W'(1);
			mem_size_q  <= MEM_SIZE_RESET;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			hit_q       <= 1'b0;
			wcnt_q      <= '0;
			addr_q      <= '0;
			pend_q      <= '0;
		end else begin
			state_q <= state_d;

			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == S_SEARCH || state_q == S_STREAM
					|| state_q == S_SQUEEZE || (state_q == S_REPORT && rep_adv)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				mem_size_q <= cfg_size;
				count_q    <= CNT_W'(1);
			end

			if (req_acc) begin
				found_q <= 1'b0;
				hit_q   <= 1'b0;
				wcnt_q  <= '0;
				addr_q  <= '0;
				pend_q  <= '0;
			end

			if (state_q == S_SEARCH && cand && better) begin
				found_q <= 1'b1;
			end

			if (state_q == S_INSERT && split) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (state_q == S_STREAM) begin
				pend_q <= pend_d;
				addr_q <= addr_d;
				wcnt_q <= wcnt_q + CNT_W'(st_out.valid);
				if (hit_now) begin
					hit_q <= 1'b1;
				end
			end

			if (state_q == S_SQUEEZE && cnt_q == CNT_LAST) begin
				count_q <= wcnt_q;
			end

			if (state_q == S_TOPHOLE && top_ok) begin
				count_q <= wcnt_q + CNT_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
			if (req.request_size == '0) begin
				res_q <= rsp_blank(STAT_BAD_SIZE);
			end else begin
				res_q <= rsp_blank(STAT_BAD_FIT);
			end
		end
		if (state_q == S_SEARCH && cand && better) begin
			pick_q   <= IDX_BITS'(cnt_q);
			pick_e_q <= head;
		end
		if (state_q == S_DECIDE) begin
			if (!found_q) begin
				res_q <= rsp_blank(STAT_NO_ROOM);
			end else if (split && count_q == CNT_FULL) begin
				res_q <= rsp_blank(STAT_FULL);
			end else begin
				res_q.status        <= STAT_OK;
				res_q.segment_begin <= pick_e_q.start;
				res_q.segment_end   <= pick_e_q.start + req_q.request_size - ADDR_BITS'(1);
				res_q.segment_owner <= req_q.owner_id;
				res_q.segment_used  <= 1'b1;
				res_q.last          <= 1'b1;
			end
		end
		if (state_q == S_SQUEEZE && cnt_q == CNT_LAST) begin
			res_q <= rsp_blank((req_q.action == ACT_RELEASE && !hit_q) ? STAT_NO_OWNER : STAT_OK);
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// The table never grows past the chain and only runs empty while compact places its
	// top hole.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 || state_q == S_TOPHOLE) && count_q <= CNT_FULL)
		else $error("segment count out of range");

	// While searching, every slot below the count must hold a live segment at the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && cnt_q < count_q) |-> head.valid)
		else $error("chain out of alignment during search");

	// A split needs a free slot at the top of the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT && split) |-> count_q < CNT_FULL)
		else $error("insert into a full table");

	// After a report result is loaded, the output register is valid or holds a used segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPORT && rsp_load) |=> (rsp_valid_q && !rsp_q.segment_used
			|| rsp_q.segment_used))
		else $error("report result lost");

endmodule

`default_nettype wire

// ----- hw/rtl/csa_cell.sv -----
`default_nettype none

module csa_cell
	import csa_pkg::*;
#(
	parameter int POS = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire entry_t    prev,
	input  wire entry_t    next,
	input  wire logic      gap_in,
	output      entry_t    q,
	output      logic      gap_out
);

	localparam logic [IDX_BITS:0] POS_W = (IDX_BITS+1)'(POS);

	entry_t ent_q;
	entry_t ent_d;
	logic [IDX_BITS:0] idx_w;

	assign idx_w   = {1'b0, cmd.idx};
	// During a squeeze, a cell moves down while any slot at or below it is empty.
	assign gap_out = gap_in | ~ent_q.valid;
	assign q       = ent_q;

	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			CELL_HOLD: begin
				ent_d = ent_q;
			end
			CELL_ROTATE: begin
				ent_d = next;
			end
			CELL_INSERT: begin
				if (idx_w == POS_W) begin
					ent_d.valid  = 1'b1;
					ent_d.taken  = 1'b1;
					ent_d.holder = cmd.owner;
					ent_d.len    = cmd.size;
				end else if (cmd.split && (idx_w + 1'b1) == POS_W) begin
					ent_d = cmd.wr;
				end else if (cmd.split && (idx_w + 1'b1) < POS_W) begin
					ent_d = prev;
				end
			end
			CELL_SQUEEZE: begin
				if (gap_out) begin
					ent_d = next;
				end
			end
			CELL_WRITE: begin
				if (idx_w == POS_W) begin
					ent_d = cmd.wr;
				end
			end
			CELL_INIT: begin
				ent_d = (POS == 0) ? cmd.wr : '0;
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= (POS == 0) ? ENTRY_RESET : '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/csa_chain.sv -----
`default_nettype none

module csa_chain
	import csa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire entry_t    feed,
	output      entry_t    head
);

	entry_t ent [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] gap;

	for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   gap_prev;

		if (j == 0) begin : g_first
			assign prev_e   = '0;
			assign gap_prev = 1'b0;
		end else begin : g_mid
			assign prev_e   = ent[j-1];
			assign gap_prev = gap[j-1];
		end

		// The top cell is fed from the controller, which closes the ring.
		if (j == MAX_SEGMENTS-1) begin : g_top
			assign next_e = feed;
		end else begin : g_below
			assign next_e = ent[j+1];
		end

		csa_cell #(.POS(j)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.prev    (prev_e),
			.next    (next_e),
			.gap_in  (gap_prev),
			.q       (ent[j]),
			.gap_out (gap[j])
		);
	end

	assign head = ent[0];

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;
	import csa_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int RANDOM_REQUESTS = 360;
	// Settle time for the slowest operation, with margin on top.
	localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 16;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	contiguous_segment_allocator #(.MAX_SEGMENTS(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the segment table, kept in the same order as the block's.
	logic [ADDR_BITS-1:0]  shadow_start [TABLE_DEPTH];
	logic [ADDR_BITS-1:0]  shadow_len   [TABLE_DEPTH];
	logic [OWNER_BITS-1:0] shadow_owner [TABLE_DEPTH];
	logic                  shadow_taken [TABLE_DEPTH];
	int                    shadow_count;
	logic [ADDR_BITS-1:0]  shadow_mem_size;

	req_t pending_requests[$];
	rsp_t expected_results[$];

	int  error_count;
	int  request_count;
	int  result_count;
	int  grant_count;
	// When set, the result side stops accepting for a long stretch.
	bit  hold_results;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("contiguous_segment_allocator: mismatch");
		$finish;
	end

	task automatic shadow_clear(input logic [ADDR_BITS-1:0] size);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			shadow_start[i] = '0;
			shadow_len[i] = '0;
			shadow_owner[i] = '0;
			shadow_taken[i] = 1'b0;
		end
		// A size of zero is taken as one byte.
		shadow_mem_size = (size == 0) ? 1 : size;
		shadow_len[0] = shadow_mem_size;
		shadow_count = 1;
	endtask

	function automatic rsp_t error_result(input status_t s);
		rsp_t r;
		r = '0;
		r.status = s;
		r.last = 1'b1;
		return r;
	endfunction

	// Merge adjacent holes after a release.
	task automatic shadow_merge_holes();
		int w;
		w = 0;
		for (int i = 1; i < shadow_count; i++) begin
			if (!shadow_taken[w] && !shadow_taken[i]) begin
				shadow_len[w] += shadow_len[i];
			end else begin
				w++;
				shadow_start[w] = shadow_start[i];
				shadow_len[w] = shadow_len[i];
				shadow_owner[w] = shadow_owner[i];
				shadow_taken[w] = shadow_taken[i];
			end
		end
		for (int i = w + 1; i < TABLE_DEPTH; i++) begin
			shadow_start[i] = '0; shadow_len[i] = '0;
			shadow_owner[i] = '0; shadow_taken[i] = 1'b0;
		end
		shadow_count = w + 1;
	endtask

	task automatic predict_allocation(input req_t r);
		int   pick;
		rsp_t res;
		pick = -1;
		if (r.request_size == 0) begin
			expected_results.push_back(error_result(STAT_BAD_SIZE));
			return;
		end
		if (r.fit_strategy == FIT_INVALID) begin
			expected_results.push_back(error_result(STAT_BAD_FIT));
			return;
		end
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_taken[i] || shadow_len[i] < r.request_size) continue;
			if (pick < 0) begin
				pick = i;
				if (r.fit_strategy == FIT_FIRST) break;
			end else if (r.fit_strategy == FIT_BEST && shadow_len[i] < shadow_len[pick]) begin
				pick = i;
			end else if (r.fit_strategy == FIT_WORST && shadow_len[i] > shadow_len[pick]) begin
				pick = i;
			end
		end
		if (pick < 0) begin
			expected_results.push_back(error_result(STAT_NO_ROOM));
			return;
		end
		if (shadow_len[pick] > r.request_size) begin
			// A split needs a free slot; an exact fit does not.
			if (shadow_count >= TABLE_DEPTH) begin
				expected_results.push_back(error_result(STAT_FULL));
				return;
			end
			for (int i = shadow_count; i > pick + 1; i--) begin
				shadow_start[i] = shadow_start[i-1];
				shadow_len[i] = shadow_len[i-1];
				shadow_owner[i] = shadow_owner[i-1];
				shadow_taken[i] = shadow_taken[i-1];
			end
			shadow_start[pick+1] = shadow_start[pick] + r.request_size;
			shadow_len[pick+1] = shadow_len[pick] - r.request_size;
			shadow_owner[pick+1] = '0;
			shadow_taken[pick+1] = 1'b0;
			shadow_count++;
		end
		shadow_len[pick] = r.request_size;
		shadow_owner[pick] = r.owner_id;
		shadow_taken[pick] = 1'b1;
		res = '0;
		res.status = STAT_OK;
		res.segment_begin = shadow_start[pick];
		res.segment_end = shadow_start[pick] + r.request_size - 1;
		res.segment_owner = r.owner_id;
		res.segment_used = 1'b1;
		res.last = 1'b1;
		expected_results.push_back(res);
	endtask

	task automatic predict_release(input logic [OWNER_BITS-1:0] owner);
		bit hit;
		hit = 0;
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_taken[i] && shadow_owner[i] == owner) begin
				shadow_taken[i] = 1'b0;
				shadow_owner[i] = '0;
				hit = 1;
			end
		end
		if (!hit) begin
			expected_results.push_back(error_result(STAT_NO_OWNER));
			return;
		end
		shadow_merge_holes();
		expected_results.push_back(error_result(STAT_OK));
	endtask

	task automatic predict_compaction();
		int w;
		logic [ADDR_BITS-1:0] addr;
		w = 0;
		addr = '0;
		for (int i = 0; i < shadow_count; i++) begin
			if (!shadow_taken[i]) continue;
			shadow_start[w] = addr;
			shadow_len[w] = shadow_len[i];
			shadow_owner[w] = shadow_owner[i];
			shadow_taken[w] = 1'b1;
			addr += shadow_len[i];
			w++;
		end
		if (addr < shadow_mem_size && w < TABLE_DEPTH) begin
			shadow_start[w] = addr;
			shadow_len[w] = shadow_mem_size - addr;
			shadow_owner[w] = '0;
			shadow_taken[w] = 1'b0;
			w++;
		end
		for (int i = w; i < TABLE_DEPTH; i++) begin
			shadow_start[i] = '0; shadow_len[i] = '0;
			shadow_owner[i] = '0; shadow_taken[i] = 1'b0;
		end
		shadow_count = w;
		expected_results.push_back(error_result(STAT_OK));
	endtask

	task automatic predict_segment_listing();
		rsp_t res;
		for (int i = 0; i < shadow_count; i++) begin
			res = '0;
			res.status = STAT_OK;
			res.segment_begin = shadow_start[i];
			res.segment_end = shadow_start[i] + shadow_len[i] - 1;
			res.segment_owner = shadow_taken[i] ? shadow_owner[i] : '0;
			res.segment_used = shadow_taken[i];
			res.last = (i == shadow_count - 1);
			expected_results.push_back(res);
		end
	endtask

	task automatic predict_request(input req_t r);
		case (r.action)
			ACT_REQUEST: predict_allocation(r);
			ACT_RELEASE: predict_release(r.owner_id);
			ACT_COMPACT: predict_compaction();
			default: predict_segment_listing();
		endcase
	endtask

	// Request driver: offers the queued requests in order, each after a randomly drawn wait.
	int send_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_wait = $urandom_range(0, 8);
		end else begin
			if (req_valid && req_ready) begin
				predict_request(req);
				request_count++;
			end
			if (!req_valid || req_ready) begin
				if (pending_requests.size() != 0 && send_wait == 0) begin
					req_valid <= 1'b1;
					req <= pending_requests.pop_front();
					send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				end else begin
					req_valid <= 1'b0;
					if (send_wait > 0 && pending_requests.size() != 0) send_wait--;
				end
			end
		end
	end

	// Result monitor: compares every accepted result and draws a stall per result.
	int recv_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d begin %0d", rsp.status,
						rsp.segment_begin);
					error_count++;
				end else begin
					rsp_t exp_r;
					exp_r = expected_results.pop_front();
					if (rsp.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, rsp.status);
						error_count++;
					end
					if (rsp.segment_begin !== exp_r.segment_begin) begin
						$error("segment_begin: expected %0d, got %0d",
							exp_r.segment_begin, rsp.segment_begin);
						error_count++;
					end
					if (rsp.segment_end !== exp_r.segment_end) begin
						$error("segment_end: expected %0d, got %0d",
							exp_r.segment_end, rsp.segment_end);
						error_count++;
					end
					if (rsp.segment_owner !== exp_r.segment_owner) begin
						$error("segment_owner: expected %0d, got %0d",
							exp_r.segment_owner, rsp.segment_owner);
						error_count++;
					end
					if (rsp.segment_used !== exp_r.segment_used) begin
						$error("segment_used: expected %0d, got %0d",
							exp_r.segment_used, rsp.segment_used);
						error_count++;
					end
					if (rsp.last !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, rsp.last);
						error_count++;
					end
					if (exp_r.status == STAT_OK && exp_r.segment_used && exp_r.last)
						grant_count++;
				end
				recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end
			if (hold_results) begin
				rsp_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// One APB write of memory_size; the table is reset by it in the shadow as well.
	task automatic write_memory_size(input logic [ADDR_BITS-1:0] size);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_MEM_SIZE);
		pwdata <= 32'(size);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		shadow_clear(size);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every request has been taken and every result checked, then lets
	// the block finish any work that produces nothing further.
	task automatic drain();
		while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic req_t make_request(input action_t a, input logic [15:0] owner,
		input logic [ADDR_BITS-1:0] size, input fit_t fit);
		req_t r;
		r.action = a;
		r.owner_id = owner;
		r.request_size = size;
		r.fit_strategy = fit;
		return r;
	endfunction

	// Mostly allocations and releases from a small pool of owners so that the table
	// fragments and fills; sizes scale with the managed memory.
	function automatic req_t random_request(input logic [ADDR_BITS-1:0] mem);
		req_t r;
		int   pick;
		r = '0;
		pick = $urandom_range(0, 99);
		r.owner_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
		r.fit_strategy = fit_t'(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2));
		if (pick < 55) begin
			r.action = ACT_REQUEST;
			case ($urandom_range(0, 9))
				0: r.request_size = ADDR_BITS'($urandom);
				1: r.request_size = '0;
				2: r.request_size = mem;
				default: r.request_size = ADDR_BITS'($urandom_range(1, (mem / 16) + 1));
			endcase
		end else if (pick < 78) begin
			r.action = ACT_RELEASE;
		end else if (pick < 86) begin
			r.action = ACT_COMPACT;
		end else begin
			r.action = ACT_REPORT;
		end
		return r;
	endfunction

	initial begin
		logic [ADDR_BITS-1:0] mem_sizes [5];
		mem_sizes = '{30'd4096, 30'h3FFFFFFF, 30'd0, 30'd1000, 30'd64};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_results = 1'b0;
		error_count = 0;
		request_count = 0;
		result_count = 0;
		grant_count = 0;
		shadow_clear(MEM_SIZE_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset-sized table: every error code but a full table, every fit,
		// an exact fit with no leftover hole, and compaction of a fragmented table.
		pending_requests.push_back(make_request(ACT_REPORT, 0, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 1, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 1, 100, FIT_INVALID));
		pending_requests.push_back(make_request(ACT_REQUEST, 1, 30'h3FFFFFFF, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 1, 100, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 2, 300, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 3, 50, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 16'hFFFF, 400, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_RELEASE, 2, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_RELEASE, 16'hFFFF, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_RELEASE, 77, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 4, 20, FIT_BEST));
		pending_requests.push_back(make_request(ACT_REQUEST, 5, 20, FIT_WORST));
		pending_requests.push_back(make_request(ACT_REQUEST, 6, 280, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REPORT, 0, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_COMPACT, 0, 0, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REPORT, 0, 0, FIT_FIRST));
		drain();

		// Fill the table on a tiny memory so that a split meets a full table,
		// then take the rest exactly.
		write_memory_size(30'd40);
		for (int i = 0; i < 32; i++)
			pending_requests.push_back(make_request(ACT_REQUEST, 16'(i + 1), 1, FIT_FIRST));
		pending_requests.push_back(make_request(ACT_REQUEST, 16'd99, 9, FIT_BEST));
		pending_requests.push_back(make_request(ACT_REPORT, 0, 0, FIT_FIRST));
		drain();

		// Random phases under several memory sizes, including the largest and zero.
		for (int phase = 0; phase < 5; phase++) begin
			write_memory_size(mem_sizes[phase]);
			if (phase == 1) begin
				// Hold results back for a long time while requests keep coming.
				hold_results = 1'b1;
				for (int i = 0; i < 20; i++)
					pending_requests.push_back(random_request(shadow_mem_size));
				repeat (400) @(posedge clk);
				hold_results = 1'b0;
			end
			for (int i = 0; i < RANDOM_REQUESTS / 5; i++) begin
				pending_requests.push_back(random_request(shadow_mem_size));
				// Occasionally stop sending until everything has come back.
				if (i == 40) begin
					while (pending_requests.size() != 0 || req_valid ||
						expected_results.size() != 0)
						@(posedge clk);
				end
			end
			pending_requests.push_back(make_request(ACT_REPORT, 0, 0, FIT_FIRST));
			drain();
		end

		$display("Ran %0d requests through first, best and worst fit, releases, compaction",
			request_count);
		$display("and listings over five memory sizes; %0d results checked, %0d grants.",
			result_count, grant_count);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("contiguous_segment_allocator: match");
		end else begin
			$display("contiguous_segment_allocator: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/csa_pkg.sv
hw/rtl/csa_cell.sv
hw/rtl/csa_chain.sv
hw/rtl/contiguous_segment_allocator.sv
dv/testbench.sv
